/* rtl/cfsf_pkg.sv */
// shared types, constants and crc helper for the can frame serial framer
`timescale 1ns / 1ps

package cfsf_pkg;

    // field widths
    localparam int unsigned ID_W   = 11;
    localparam int unsigned LEN_W  = 4;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned TS_W   = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 5;

    // crc and framing constants
    localparam logic [15:0]       CRC_INIT = 16'hFFFF;
    localparam logic [15:0]       CRC_POLY = 16'hA001;
    localparam logic [BYTE_W-1:0] EOF_MARK = 8'h7E;
    localparam logic [LEN_W-1:0]  LEN_CAP  = 4'd8;

    // byte positions within a frame
    localparam logic [IDX_W-1:0] IDX_TS_END = 5'd4;
    localparam logic [IDX_W-1:0] IDX_ID_HI  = 5'd4;
    localparam logic [IDX_W-1:0] IDX_ID_LO  = 5'd5;
    localparam logic [IDX_W-1:0] IDX_LEN    = 5'd6;
    localparam logic [IDX_W-1:0] IDX_DATA   = 5'd7;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic slot_free;
        logic at_eof;
    } t_dp_sts;

    // one byte through the reflected crc-16, bit at a time
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data_in);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/cfsf_if.sv */
// valid/ready channel interfaces for message input and byte output
`timescale 1ns / 1ps

// message channel
interface cfsf_msg_if import cfsf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   can_id;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] payload;
    logic [TS_W-1:0]   timestamp;

    modport source (output valid, output can_id, output length, output payload,
                    output timestamp, input ready);
    modport sink   (input valid, input can_id, input length, input payload,
                    input timestamp, output ready);
endinterface

// byte channel
interface cfsf_byte_if import cfsf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte_value;
    logic              last;

    modport source (output valid, output out_byte_value, output last, input ready);
    modport sink   (input valid, input out_byte_value, input last, output ready);
endinterface

/* rtl/cfsf_ctrl.sv */
// controller state machine for the framer: load a message, then step bytes out
`timescale 1ns / 1ps

module cfsf_ctrl import cfsf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_msg_valid,
    output logic    o_msg_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // commands and next state
    always_comb begin
        n_state     = r_state;
        o_msg_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_msg_ready = 1'b1;
                if (i_msg_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (i_sts.slot_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.at_eof) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/cfsf_dp.sv */
// datapath for the framer: message registers, byte select, crc and output stage
`timescale 1ns / 1ps

module cfsf_dp import cfsf_pkg::*; #(
    parameter int unsigned MAX_DATA_BYTES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [ID_W-1:0]   i_can_id,
    input  logic [LEN_W-1:0]  i_length,
    input  logic [DATA_W-1:0] i_payload,
    input  logic [TS_W-1:0]   i_timestamp,
    output logic              o_byte_valid,
    input  logic              i_byte_ready,
    output logic [BYTE_W-1:0] o_byte_value,
    output logic              o_last
);

    localparam int unsigned NB   = (MAX_DATA_BYTES > 8) ? 8 :
                                   ((MAX_DATA_BYTES < 1) ? 1 : MAX_DATA_BYTES);
    localparam int unsigned DI_W = (NB > 1) ? $clog2(NB) : 1;
    localparam logic [LEN_W-1:0] LIM = LEN_W'(NB);

    logic [ID_W-1:0]   r_id;
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_data [NB];
    logic [TS_W-1:0]   r_ts;
    logic [IDX_W-1:0]  r_idx;
    logic [15:0]       r_crc;
    logic              r_ov;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic [LEN_W-1:0]  n_len;
    logic [IDX_W-1:0]  data_end;
    logic [IDX_W-1:0]  data_off;
    logic [DI_W-1:0]   data_sel;
    logic [BYTE_W-1:0] cur_byte;
    logic              covered;
    logic              at_eof;

    // clamp the length code
    assign n_len = (i_length > LIM) ? LIM : i_length;

    // byte position decode
    assign data_end = IDX_DATA + IDX_W'(r_len);
    assign data_off = r_idx - IDX_DATA;
    assign data_sel = data_off[DI_W-1:0];
    assign covered  = (r_idx < data_end);
    assign at_eof   = (r_idx == data_end + IDX_W'(2));

    // current frame byte
    always_comb begin
        if (r_idx < IDX_TS_END) begin
            cur_byte = r_ts[{r_idx[1:0], 3'b000} +: BYTE_W];
        end else if (r_idx == IDX_ID_HI) begin
            cur_byte = {{(2*BYTE_W-ID_W){1'b0}}, r_id[ID_W-1:BYTE_W]};
        end else if (r_idx == IDX_ID_LO) begin
            cur_byte = r_id[BYTE_W-1:0];
        end else if (r_idx == IDX_LEN) begin
            cur_byte = {{(BYTE_W-LEN_W){1'b0}}, r_len};
        end else if (covered) begin
            cur_byte = r_data[data_sel];
        end else if (r_idx == data_end) begin
            cur_byte = r_crc[15:8];
        end else if (r_idx == data_end + IDX_W'(1)) begin
            cur_byte = r_crc[7:0];
        end else begin
            cur_byte = EOF_MARK;
        end
    end

    // status to controller
    assign o_sts.slot_free = !r_ov || i_byte_ready;
    assign o_sts.at_eof    = at_eof;

    // message capture, index and crc
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id  <= i_can_id;
            r_len <= n_len;
            r_ts  <= i_timestamp;
            for (int j = 0; j < NB; j++) begin
                r_data[j] <= i_payload[8*j +: 8];
            end
            r_idx <= '0;
            r_crc <= CRC_INIT;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (covered) begin
                r_crc <= crc_byte(r_crc, cur_byte);
            end
        end
    end

    // output stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.step) begin
            r_ov <= 1'b1;
        end else if (i_byte_ready) begin
            r_ov <= 1'b0;
        end
    end

    // output stage payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_byte <= cur_byte;
            r_out_last <= at_eof;
        end
    end

    assign o_byte_valid = r_ov;
    assign o_byte_value = r_out_byte;
    assign o_last       = r_out_last;

endmodule

/* rtl/can_frame_serial_framer_top.sv */
// top level of the can frame serial framer: crc-16 framed byte stream per message
// a message is taken in the idle state and captured into the message registers
// bytes then leave through the output register one per cycle while the sink is ready:
// 10 + length bytes, length clamped to MAX_DATA_BYTES (itself limited to 1..8)
// the next message can be taken once the final 0x7E byte sits in the output register
// synchronous active-low reset clears the controller state and the output valid
`timescale 1ns / 1ps

module can_frame_serial_framer_top import cfsf_pkg::*; #(
    parameter int unsigned MAX_DATA_BYTES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cfsf_msg_if.sink    i_msg,
    cfsf_byte_if.source o_byte
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    msg_ready;

    assign i_msg.ready = msg_ready;

    // control
    cfsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_msg_valid (i_msg.valid),
        .o_msg_ready (msg_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // datapath
    cfsf_dp #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_can_id     (i_msg.can_id),
        .i_length     (i_msg.length),
        .i_payload    (i_msg.payload),
        .i_timestamp  (i_msg.timestamp),
        .o_byte_valid (o_byte.valid),
        .i_byte_ready (o_byte.ready),
        .o_byte_value (o_byte.out_byte_value),
        .o_last       (o_byte.last)
    );

endmodule
